[rtl/rwdm_pkg.sv]
package rwdm_pkg;

  localparam int LenW    = 31;
  localparam int TimeW   = 32;
  localparam int DutyW   = 10;
  localparam int ProdW   = TimeW + DutyW;
  localparam int StepW   = 4;

  localparam logic [LenW-1:0]  LEN_RESET = LenW'(8000);
  localparam logic [DutyW-1:0] PERMILLE  = DutyW'(1000);
  localparam logic [StepW-1:0] LAST_STEP = StepW'(DutyW - 1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_WAKE = 1'b1;

  typedef struct packed {
    logic accept;
    logic clamp;
    logic mul;
    logic div_step;
    logic load_out;
  } rwdm_cmd_t;

  typedef struct packed {
    logic div_last;
  } rwdm_status_t;

endpackage

[rtl/retriggerable_window_duty_meter.sv]
// Retriggerable window duty meter.
// Input channel (in_valid/in_ready): one item per tick or wake event, with
// the event kind, a wrapping millisecond timestamp and the span over which
// the duty reading is taken. Output channel (out_valid/out_ready): one
// result item per input item, giving the window state after the event, the
// window count, the accumulated open time and the duty in permille.
// Configuration channel (cfg_valid/cfg_ready): writes the window length in
// milliseconds; it is always ready and is meant to be written while idle.
//
// Operation: an accepted item passes through a clamp state, a multiply
// state and a restoring divider that yields one duty bit per cycle, and
// its result is then loaded into the output register once that is free.
// A new item is accepted only after the previous result has been loaded.
//
// Reset (rst_n low, synchronous) closes the window, clears all counters and
// timestamps and loads the default window length of 8000 ms. If the
// receiver stalls, the finished result waits in the output register while
// the next item is accepted and processed; that item then waits for the
// output register to free before it is delivered.
module retriggerable_window_duty_meter
  import rwdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LenW-1:0]   cfg_window_length_ms,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [TimeW-1:0]  in_now_ms,
  input  logic [TimeW-1:0]  in_elapsed_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_open,
  output logic [DutyW-1:0]  out_duty_permille,
  output logic [TimeW-1:0]  out_window_total,
  output logic [TimeW-1:0]  out_open_time_ms
);

  rwdm_cmd_t    cmd;
  rwdm_status_t status;

  // The length register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: accept, clamp, multiply, divide, then hand to output.
  rwdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Window state, duty arithmetic and the output register.
  rwdm_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_window_length_ms (cfg_window_length_ms),
    .in_op                (in_op),
    .in_now_ms            (in_now_ms),
    .in_elapsed_ms        (in_elapsed_ms),
    .cmd                  (cmd),
    .status               (status),
    .out_is_open          (out_is_open),
    .out_duty_permille    (out_duty_permille),
    .out_window_total     (out_window_total),
    .out_open_time_ms     (out_open_time_ms)
  );

endmodule

[rtl/rwdm_ctrl.sv]
module rwdm_ctrl
  import rwdm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output rwdm_cmd_t    cmd,
  input  rwdm_status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLAMP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/rwdm_dp.sv]
module rwdm_dp
  import rwdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [LenW-1:0]    cfg_window_length_ms,
  input  logic               in_op,
  input  logic [TimeW-1:0]   in_now_ms,
  input  logic [TimeW-1:0]   in_elapsed_ms,
  input  rwdm_cmd_t          cmd,
  output rwdm_status_t       status,
  output logic               out_is_open,
  output logic [DutyW-1:0]   out_duty_permille,
  output logic [TimeW-1:0]   out_window_total,
  output logic [TimeW-1:0]   out_open_time_ms
);

  logic [LenW-1:0]  len_r;
  logic             open_r;
  logic [TimeW-1:0] deadline_r, mark_r, accum_r, count_r;
  logic [TimeW-1:0] span_r, t_r;
  logic             span_zero_r;
  logic [ProdW-1:0] rem_r, dsh_r;
  logic [DutyW-1:0] quot_r;
  logic [StepW-1:0] step_r;
  logic             is_open_r;
  logic [DutyW-1:0] duty_r;
  logic [TimeW-1:0] total_r, otime_r;

  logic [TimeW-1:0] gap;
  logic [TimeW-1:0] since_dl;
  logic             reached;
  logic             fits;

  assign gap      = in_now_ms - mark_r;
  assign since_dl = in_now_ms - deadline_r;
  assign reached  = !since_dl[TimeW-1];
  assign fits     = (rem_r >= dsh_r);
  assign status.div_last = (step_r == LAST_STEP);

  // Control state: configuration register and window tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= LEN_RESET;
      open_r     <= 1'b0;
      deadline_r <= '0;
      mark_r     <= '0;
      accum_r    <= '0;
      count_r    <= '0;
      step_r     <= '0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_window_length_ms;
      end
      if (cmd.accept) begin
        mark_r <= in_now_ms;
        if (open_r) begin
          accum_r <= accum_r + gap;
        end
        if (in_op == OP_WAKE) begin
          if (!open_r) begin
            open_r  <= 1'b1;
            count_r <= count_r + 1'b1;
          end
          deadline_r <= in_now_ms + {1'b0, len_r};
        end else if (open_r && reached) begin
          open_r <= 1'b0;
        end
      end
      if (cmd.mul) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // Duty reading: clamp, multiply by 1000, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      span_r      <= in_elapsed_ms;
      span_zero_r <= (in_elapsed_ms == '0);
    end
    if (cmd.clamp) begin
      t_r <= (accum_r > span_r) ? span_r : accum_r;
    end
    if (cmd.mul) begin
      rem_r  <= ProdW'(t_r) * ProdW'(PERMILLE);
      dsh_r  <= ProdW'({span_r, {(DutyW-1){1'b0}}});
      quot_r <= '0;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quot_r <= {quot_r[DutyW-2:0], fits};
      dsh_r  <= dsh_r >> 1;
    end
    if (cmd.load_out) begin
      is_open_r <= open_r;
      duty_r    <= span_zero_r ? '0 : quot_r;
      total_r   <= count_r;
      otime_r   <= accum_r;
    end
  end

  assign out_is_open       = is_open_r;
  assign out_duty_permille = duty_r;
  assign out_window_total  = total_r;
  assign out_open_time_ms  = otime_r;

endmodule

[test/testbench.sv]
module testbench;
  import rwdm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Clock period, reset length and the run's limits.
  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 7;
  localparam int QuietLimit    = 2000;
  localparam int SettleCycles  = 40;
  localparam int HoldCycles    = 250;
  localparam int MaxReports    = 10;
  localparam int PhaseCount    = 8;
  localparam int ItemsPerPhase = 80;
  localparam int DirectedCount = 16;

  // One duty reading as the block reports it, field for field.
  typedef struct packed {
    logic             is_open;
    logic [DutyW-1:0] duty;
    logic [TimeW-1:0] windows;
    logic [TimeW-1:0] open_ms;
  } duty_reading_t;

  // One row of the directed table. Rows with known set carry a reading
  // typed in by hand; the others are checked against the predictor.
  typedef struct packed {
    logic             op;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] span_ms;
    logic             known;
    duty_reading_t    reading;
  } event_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LenW-1:0]   cfg_window_length_ms = LEN_RESET;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = OP_TICK;
  logic [TimeW-1:0]  in_now_ms = '0;
  logic [TimeW-1:0]  in_elapsed_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_is_open;
  logic [DutyW-1:0]  out_duty_permille;
  logic [TimeW-1:0]  out_window_total;
  logic [TimeW-1:0]  out_open_time_ms;

  retriggerable_window_duty_meter dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_window_length_ms (cfg_window_length_ms),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_now_ms            (in_now_ms),
    .in_elapsed_ms        (in_elapsed_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_open          (out_is_open),
    .out_duty_permille    (out_duty_permille),
    .out_window_total     (out_window_total),
    .out_open_time_ms     (out_open_time_ms)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Shadow copy of the meter's state and its window length register.
  logic [LenW-1:0]  win_len_ms;
  logic             win_open;
  logic [TimeW-1:0] win_deadline;
  logic [TimeW-1:0] win_last_mark;
  logic [TimeW-1:0] win_open_accum;
  logic [TimeW-1:0] win_count;

  // Readings still owed by the block, oldest first.
  duty_reading_t pending_readings[$];

  int unsigned mismatch_count   = 0;
  int unsigned readings_checked = 0;
  int unsigned events_sent      = 0;
  int unsigned wakes_sent       = 0;
  int unsigned lengths_applied  = 0;
  int unsigned quiet_cycles     = 0;

  // Idle and stall rates in percent for the current phase.
  int unsigned sender_idle_pct  = 0;
  int unsigned stall_pct        = 0;

  // The long receiver hold-off is requested by bumping hold_request; the
  // receiver process notices the change and counts the stretch itself.
  int unsigned hold_request     = 0;
  int unsigned hold_served      = 0;
  int unsigned hold_left        = 0;

  // Timestamp the random stimulus has reached so far.
  logic [TimeW-1:0] stamp_ms;

  function automatic void clear_meter();
    win_len_ms     = LEN_RESET;
    win_open       = 1'b0;
    win_deadline   = '0;
    win_last_mark  = '0;
    win_open_accum = '0;
    win_count      = '0;
  endfunction

  // Advances the shadow state by one event and returns the reading that the
  // block must give for it.
  function automatic duty_reading_t predict_duty_reading(input logic op,
                                                         input logic [TimeW-1:0] now,
                                                         input logic [TimeW-1:0] span);
    duty_reading_t    r;
    logic [TimeW-1:0] clamped;
    logic [TimeW-1:0] past_deadline;
    logic [ProdW-1:0] scaled;

    // Open time runs up to this event, whatever the event turns out to be.
    // A timestamp that goes backward wraps and is added as it is.
    if (win_open) begin
      win_open_accum = win_open_accum + (now - win_last_mark);
    end
    win_last_mark = now;

    if (op == OP_WAKE) begin
      // Only a wake on a closed window starts a new one; on an open window
      // it just pushes the deadline out.
      if (!win_open) begin
        win_open  = 1'b1;
        win_count = win_count + 1'b1;
      end
      win_deadline = now + {1'b0, win_len_ms};
    end else begin
      // The deadline has been reached when the wrapped difference is not
      // negative as a 32-bit signed number.
      past_deadline = now - win_deadline;
      if (win_open && !past_deadline[TimeW-1]) begin
        win_open = 1'b0;
      end
    end

    // A zero span reads as zero duty; otherwise the open time is clamped to
    // the span so the reading tops out at 1000.
    r.duty = '0;
    if (span != '0) begin
      clamped = (win_open_accum > span) ? span : win_open_accum;
      scaled  = ProdW'(clamped) * ProdW'(PERMILLE);
      r.duty  = DutyW'(scaled / ProdW'(span));
    end
    r.is_open = win_open;
    r.windows = win_count;
    r.open_ms = win_open_accum;
    return r;
  endfunction

  // Offers one event on the input channel after an optional idle gap and
  // returns, once the block has taken it, the reading it must produce.
  // Valid is only lowered when a gap is taken, so back-to-back events keep
  // it high without a second assignment in the same step.
  task automatic offer_event(input logic op, input logic [TimeW-1:0] now,
                             input logic [TimeW-1:0] span,
                             output duty_reading_t predicted);
    int unsigned gap;

    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_now_ms     <= now;
    in_elapsed_ms <= span;
    do @(posedge clk); while (!in_ready);
    predicted = predict_duty_reading(op, now, span);
    events_sent++;
    if (op == OP_WAKE) begin
      wakes_sent++;
    end
  endtask

  // Writes the window length once the block has delivered every reading.
  // Every event yields a reading, so an empty queue means the block is idle.
  task automatic write_window_length(input logic [LenW-1:0] len);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_valid            <= 1'b1;
    cfg_window_length_ms <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    win_len_ms = len;
    lengths_applied++;
  endtask

  // One random event. Most events move the clock forward by up to about two
  // window lengths, so windows open, stretch and lapse in a natural way;
  // a few jump anywhere or step backward.
  task automatic random_event();
    logic [63:0]      reach64;
    logic [TimeW-1:0] reach;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] span;
    logic             op;
    duty_reading_t    predicted;

    reach64 = 64'(win_len_ms) * 2 + 64'd2;
    reach   = (reach64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : reach64[TimeW-1:0];
    case ($urandom_range(19))
      0, 1: begin
        now = $urandom;
      end
      2: begin
        now = stamp_ms - $urandom_range(0, 50);
      end
      default: begin
        now = stamp_ms + $urandom_range(0, reach);
      end
    endcase
    stamp_ms = now;
    op = ($urandom_range(99) < 30) ? OP_WAKE : OP_TICK;

    // Spans near the open-time total give readings across the whole scale;
    // the rest hit zero, tiny and huge spans.
    case ($urandom_range(9))
      0: begin
        span = '0;
      end
      1: begin
        span = $urandom;
      end
      2: begin
        span = $urandom_range(1, 3);
      end
      3: begin
        span = 32'hFFFF_FFFF;
      end
      default: begin
        span = win_open_accum + ($urandom >> $urandom_range(0, 31));
      end
    endcase

    offer_event(op, now, span, predicted);
    pending_readings.push_back(predicted);
  endtask

  task automatic flag_reading(input string why, input duty_reading_t want,
                              input duty_reading_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("[%0t] %s: expected open=%0d duty=%0d windows=%0d open_ms=%0d", $time, why,
               want.is_open, want.duty, want.windows, want.open_ms);
      $display("[%0t] %s:      got open=%0d duty=%0d windows=%0d open_ms=%0d", $time, why,
               got.is_open, got.duty, got.windows, got.open_ms);
    end
  endtask

  // Receiver: checks each delivered reading against the oldest one owed,
  // then picks out_ready for the next cycle. A requested hold-off keeps
  // ready low until its countdown runs out; otherwise it stalls at random.
  always @(posedge clk) begin : drain_readings
    duty_reading_t got;
    duty_reading_t want;

    if (rst_n && out_valid && out_ready) begin
      got = '{out_is_open, out_duty_permille, out_window_total, out_open_time_ms};
      readings_checked++;
      if (pending_readings.size() == 0) begin
        flag_reading("reading with none pending", '0, got);
      end else begin
        want = pending_readings.pop_front();
        if (got.is_open !== want.is_open || got.duty !== want.duty ||
            got.windows !== want.windows || got.open_ms !== want.open_ms) begin
          flag_reading("reading mismatch", want, got);
        end
      end
    end

    if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no item moved for %0d cycles, %0d readings outstanding.",
               QuietLimit, pending_readings.size());
      $display("** retriggerable_window_duty_meter: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed events under the reset window length of 8000 ms. The first
  // rows walk one window through its life: a tick while closed, a wake with
  // a zero span, a reading that fills its span exactly, a close exactly at
  // the deadline under the widest span, a reading while closed, a reopening
  // and a re-arm whose open time is clamped to a tiny span. The rest cross
  // the wrap of the timestamp, step backward in time, close across the sign
  // boundary of the deadline difference and wake twice at one timestamp,
  // opening a closed window and then re-arming the open one.
  event_row_t directed_rows [DirectedCount] = '{
    '{OP_TICK, 32'd0,          32'd0,          1'b1, '{1'b0, 10'd0,    32'd0, 32'd0}},
    '{OP_WAKE, 32'd1000,       32'd0,          1'b1, '{1'b1, 10'd0,    32'd1, 32'd0}},
    '{OP_TICK, 32'd5000,       32'd4000,       1'b1, '{1'b1, 10'd1000, 32'd1, 32'd4000}},
    '{OP_TICK, 32'd9000,       32'hFFFF_FFFF,  1'b1, '{1'b0, 10'd0,    32'd1, 32'd8000}},
    '{OP_TICK, 32'd20000,      32'd16000,      1'b1, '{1'b0, 10'd500,  32'd1, 32'd8000}},
    '{OP_WAKE, 32'd20000,      32'd8000,       1'b1, '{1'b1, 10'd1000, 32'd2, 32'd8000}},
    '{OP_WAKE, 32'd25000,      32'd3,          1'b1, '{1'b1, 10'd1000, 32'd2, 32'd13000}},
    '{OP_TICK, 32'hFFFF_FFFF,  32'd1,          1'b0, '0},
    '{OP_TICK, 32'h0000_0010,  32'hFFFF_FFFF,  1'b0, '0},
    '{OP_WAKE, 32'h0000_0005,  32'd100,        1'b0, '0},
    '{OP_TICK, 32'h8000_1005,  32'h8000_0000,  1'b0, '0},
    '{OP_WAKE, 32'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b0, '0},
    '{OP_TICK, 32'h8000_1F3F,  32'd0,          1'b0, '0},
    '{OP_TICK, 32'h8000_1F40,  32'd1000,       1'b0, '0},
    '{OP_WAKE, 32'h8000_2000,  32'd0,          1'b0, '0},
    '{OP_WAKE, 32'h8000_2000,  32'h5555_5555,  1'b0, '0}
  };

  // Window lengths for the random phases: both extremes, zero (which closes
  // on the very next tick), the reset value and a few in between.
  logic [LenW-1:0] phase_lengths [PhaseCount];

  initial begin : run_meter
    duty_reading_t predicted;

    phase_lengths = '{31'd1, 31'd0, 31'd37, 31'h7FFF_FFFF,
                      31'd8000, 31'($urandom_range(100, 100000)), 31'h4000_0000, 31'd1000};

    // Synchronous reset, released once and never asserted again.
    clear_meter();
    stamp_ms = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling on either side.
    foreach (directed_rows[i]) begin
      offer_event(directed_rows[i].op, directed_rows[i].now_ms, directed_rows[i].span_ms,
                  predicted);
      if (directed_rows[i].known) begin
        pending_readings.push_back(directed_rows[i].reading);
      end else begin
        pending_readings.push_back(predicted);
      end
      stamp_ms = directed_rows[i].now_ms;
    end

    // Random phases: each writes a new window length while idle and then
    // runs under one idling pattern, cycling through none, sender only,
    // receiver only and both.
    for (int p = 0; p < PhaseCount; p++) begin
      write_window_length(phase_lengths[p]);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct      <= 0;
        end
        1: begin
          sender_idle_pct = 57;
          stall_pct      <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct      <= 57;
        end
        default: begin
          sender_idle_pct = 16;
          stall_pct      <= 16;
        end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // In the first phase the receiver holds off for a long stretch while
        // events keep coming back to back, so the block backs up and has to
        // stall its input.
        if (p == 0 && i == 20) begin
          hold_request <= hold_request + 1;
        end
        random_event();
      end
    end

    // Drain: park the input, wait for every reading, then give the block
    // time to show any reading it should not produce.
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Ran %0d events (%0d wakes) over %0d window lengths from 0 to 2^31-1;",
             events_sent, wakes_sent, lengths_applied + 1);
    $display("checked %0d readings, %0d mismatched.", readings_checked, mismatch_count);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("** retriggerable_window_duty_meter: PASSED **");
    end else begin
      $display("** retriggerable_window_duty_meter: FAILED **");
    end
    $finish;
  end

endmodule
